### sv/gcbc_pkg.sv
// Shared types, constants and helpers for the glyph coverage blender.
`default_nettype none
package gcbc_pkg;

   localparam int unsigned CHAN_W  = 8;
   localparam int unsigned CLIP_W  = 14;
   localparam int unsigned COORD_W = 16;
   localparam int unsigned RGB_W   = 24;
   localparam int unsigned PIXEL_W = 32;
   localparam int unsigned PROD_W  = 16;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 14;

   localparam logic [CHAN_W-1:0] CHAN_MAX     = 8'hFF;
   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEXT_RED    = 3'd0,
      CSR_TEXT_GREEN  = 3'd1,
      CSR_TEXT_BLUE   = 3'd2,
      CSR_TEXT_ALPHA  = 3'd3,
      CSR_CLIP_LEFT   = 3'd4,
      CSR_CLIP_TOP    = 3'd5,
      CSR_CLIP_RIGHT  = 3'd6,
      CSR_CLIP_BOTTOM = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [CHAN_W-1:0] text_red;
      logic [CHAN_W-1:0] text_green;
      logic [CHAN_W-1:0] text_blue;
      logic [CHAN_W-1:0] text_alpha;
      logic [CLIP_W-1:0] clip_left;
      logic [CLIP_W-1:0] clip_top;
      logic [CLIP_W-1:0] clip_right;
      logic [CLIP_W-1:0] clip_bottom;
   } cfg_type;

   // clip test done, coverage times text alpha
   typedef struct packed {
      logic              valid;
      logic              hit;
      logic [PROD_W-1:0] product;
      logic [RGB_W-1:0]  dest;
   } clip_stage_type;

   // effective alpha known
   typedef struct packed {
      logic              valid;
      logic              write;
      logic [CHAN_W-1:0] alpha;
      logic [RGB_W-1:0]  dest;
   } alpha_stage_type;

   // weighted channel sums before the final divide
   typedef struct packed {
      logic              valid;
      logic              write;
      logic [PROD_W-1:0] sum_red;
      logic [PROD_W-1:0] sum_green;
      logic [PROD_W-1:0] sum_blue;
   } sum_stage_type;

   typedef struct packed {
      logic               valid;
      logic               write_enable;
      logic [PIXEL_W-1:0] new_pixel;
   } out_stage_type;

   // exact floor(x / 255) for x <= 255 * 255
   function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
      logic [PROD_W:0] t;
      t = {1'b0, x} + {9'd0, x[PROD_W-1:CHAN_W]} + 17'd1;
      return t[PROD_W-1:CHAN_W];
   endfunction

endpackage
`default_nettype wire

### sv/gcbc_req_if.sv
// Input channel: coverage beat with target coordinates and destination pixel.
`default_nettype none
interface gcbc_req_if;
   logic                valid;
   logic                ready;
   logic [7:0]          coverage;
   logic signed [15:0]  target_column;
   logic signed [15:0]  target_row;
   logic [23:0]         dest_rgb;

   modport source (output valid, output coverage, output target_column,
                   output target_row, output dest_rgb, input ready);
   modport sink   (input valid, input coverage, input target_column,
                   input target_row, input dest_rgb, output ready);
endinterface
`default_nettype wire

### sv/gcbc_rsp_if.sv
// Result channel: write enable and blended ARGB pixel.
`default_nettype none
interface gcbc_rsp_if;
   logic        valid;
   logic        ready;
   logic        write_enable;
   logic [31:0] new_pixel;

   modport source (output valid, output write_enable, output new_pixel,
                   input ready);
   modport sink   (input valid, input write_enable, input new_pixel,
                   output ready);
endinterface
`default_nettype wire

### sv/glyph_coverage_blend_clip.sv
// Glyph coverage blender with clip rectangle: top level.
// Accepts one coverage beat per clock while the pipeline can advance, and
// returns one result beat per input beat, in order. An accepted beat passes
// through the register stages in order and its result is valid on rsp_chan
// once it reaches the output register. The four register stages are: clip
// test and the coverage by text alpha multiply; the divide to effective
// alpha; the per-channel weighted sums; the final divide and packing into
// the output register. The whole pipeline advances together whenever the
// output register is empty or its beat is taken, so req_chan.ready follows
// rsp_chan.ready combinationally.
// Colour, alpha and clip registers are written through the csr_ port and
// should only change while no beats are in flight.
`default_nettype none
module glyph_coverage_blend_clip (
   input  logic                              clock,
   input  logic                              reset,
   gcbc_req_if.sink                          req_chan,
   gcbc_rsp_if.source                        rsp_chan,
   input  logic                              csr_write_enable,
   input  logic [gcbc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gcbc_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import gcbc_pkg::*;

   cfg_type         cfg_ff;
   alpha_stage_type alpha_stage;
   out_stage_type   out_stage;
   logic            advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.text_red    <= 8'd0;
         cfg_ff.text_green  <= 8'd0;
         cfg_ff.text_blue   <= 8'd0;
         cfg_ff.text_alpha  <= 8'd255;
         cfg_ff.clip_left   <= 14'd0;
         cfg_ff.clip_top    <= 14'd0;
         cfg_ff.clip_right  <= 14'd4096;
         cfg_ff.clip_bottom <= 14'd4096;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_TEXT_RED:    cfg_ff.text_red    <= csr_write_data[CHAN_W-1:0];
            CSR_TEXT_GREEN:  cfg_ff.text_green  <= csr_write_data[CHAN_W-1:0];
            CSR_TEXT_BLUE:   cfg_ff.text_blue   <= csr_write_data[CHAN_W-1:0];
            CSR_TEXT_ALPHA:  cfg_ff.text_alpha  <= csr_write_data[CHAN_W-1:0];
            CSR_CLIP_LEFT:   cfg_ff.clip_left   <= csr_write_data[CLIP_W-1:0];
            CSR_CLIP_TOP:    cfg_ff.clip_top    <= csr_write_data[CLIP_W-1:0];
            CSR_CLIP_RIGHT:  cfg_ff.clip_right  <= csr_write_data[CLIP_W-1:0];
            CSR_CLIP_BOTTOM: cfg_ff.clip_bottom <= csr_write_data[CLIP_W-1:0];
            default: ;
         endcase
      end
   end

   assign advance        = !out_stage.valid || rsp_chan.ready;
   assign req_chan.ready = advance;

   gcbc_alpha u_alpha (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .cfg         (cfg_ff),
      .in_valid    (req_chan.valid),
      .in_coverage (req_chan.coverage),
      .in_column   (req_chan.target_column),
      .in_row      (req_chan.target_row),
      .in_dest     (req_chan.dest_rgb),
      .stage_out   (alpha_stage)
   );

   gcbc_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cfg       (cfg_ff),
      .stage_in  (alpha_stage),
      .stage_out (out_stage)
   );

   assign rsp_chan.valid        = out_stage.valid;
   assign rsp_chan.write_enable = out_stage.write_enable;
   assign rsp_chan.new_pixel    = out_stage.new_pixel;

endmodule
`default_nettype wire

### sv/gcbc_alpha.sv
// Stages 1-2: clip test, coverage times text alpha, divide to effective alpha.
`default_nettype none
module gcbc_alpha (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  gcbc_pkg::cfg_type          cfg,
   input  logic                       in_valid,
   input  logic [7:0]                 in_coverage,
   input  logic signed [15:0]         in_column,
   input  logic signed [15:0]         in_row,
   input  logic [23:0]                in_dest,
   output gcbc_pkg::alpha_stage_type  stage_out
);
   import gcbc_pkg::*;

   clip_stage_type  clip_ff, clip_in;
   alpha_stage_type alpha_ff, alpha_in;
   logic            in_clip;
   logic [CHAN_W-1:0] alpha;

   always_comb begin
      in_clip = (in_column >= $signed({2'b00, cfg.clip_left}))
             && (in_column <  $signed({2'b00, cfg.clip_right}))
             && (in_row    >= $signed({2'b00, cfg.clip_top}))
             && (in_row    <  $signed({2'b00, cfg.clip_bottom}));
      clip_in.valid   = in_valid;
      clip_in.hit     = in_clip && (in_coverage != '0);
      clip_in.product = PROD_W'(in_coverage) * PROD_W'(cfg.text_alpha);
      clip_in.dest    = in_dest;
   end

   always_comb begin
      alpha          = div255(clip_ff.product);
      alpha_in.valid = clip_ff.valid;
      alpha_in.write = clip_ff.hit && (alpha != '0);
      alpha_in.alpha = alpha;
      alpha_in.dest  = clip_ff.dest;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_ff.valid  <= 1'b0;
         alpha_ff.valid <= 1'b0;
      end else if (advance) begin
         clip_ff.valid  <= clip_in.valid;
         alpha_ff.valid <= alpha_in.valid;
      end
      if (advance) begin
         clip_ff.hit      <= clip_in.hit;
         clip_ff.product  <= clip_in.product;
         clip_ff.dest     <= clip_in.dest;
         alpha_ff.write   <= alpha_in.write;
         alpha_ff.alpha   <= alpha_in.alpha;
         alpha_ff.dest    <= alpha_in.dest;
      end
   end

   assign stage_out = alpha_ff;

endmodule
`default_nettype wire

### sv/gcbc_mix.sv
// Stages 3-4: per-channel weighted sums, divide by 255, pack ARGB.
`default_nettype none
module gcbc_mix (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  gcbc_pkg::cfg_type          cfg,
   input  gcbc_pkg::alpha_stage_type  stage_in,
   output gcbc_pkg::out_stage_type    stage_out
);
   import gcbc_pkg::*;

   sum_stage_type sum_ff, sum_in;
   out_stage_type out_ff, out_in;
   logic [CHAN_W-1:0] inv_alpha;

   always_comb begin
      inv_alpha        = CHAN_MAX - stage_in.alpha;
      sum_in.valid     = stage_in.valid;
      sum_in.write     = stage_in.write;
      sum_in.sum_red   = (PROD_W'(cfg.text_red) * PROD_W'(stage_in.alpha))
                       + (PROD_W'(stage_in.dest[23:16]) * PROD_W'(inv_alpha));
      sum_in.sum_green = (PROD_W'(cfg.text_green) * PROD_W'(stage_in.alpha))
                       + (PROD_W'(stage_in.dest[15:8]) * PROD_W'(inv_alpha));
      sum_in.sum_blue  = (PROD_W'(cfg.text_blue) * PROD_W'(stage_in.alpha))
                       + (PROD_W'(stage_in.dest[7:0]) * PROD_W'(inv_alpha));
   end

   always_comb begin
      out_in.valid        = sum_ff.valid;
      out_in.write_enable = sum_ff.write;
      if (sum_ff.write) begin
         out_in.new_pixel = {ALPHA_OPAQUE, div255(sum_ff.sum_red),
                             div255(sum_ff.sum_green), div255(sum_ff.sum_blue)};
      end else begin
         out_in.new_pixel = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff.valid <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (advance) begin
         sum_ff.valid <= sum_in.valid;
         out_ff.valid <= out_in.valid;
      end
      if (advance) begin
         sum_ff.write        <= sum_in.write;
         sum_ff.sum_red      <= sum_in.sum_red;
         sum_ff.sum_green    <= sum_in.sum_green;
         sum_ff.sum_blue     <= sum_in.sum_blue;
         out_ff.write_enable <= out_in.write_enable;
         out_ff.new_pixel    <= out_in.new_pixel;
      end
   end

   assign stage_out = out_ff;

endmodule
`default_nettype wire

### sv/gcbc_checker.sv
// Port-level checks for the glyph coverage blender, bound to the top level.
`default_nettype none
module gcbc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_write_enable,
   input logic [31:0] rsp_new_pixel
);

   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_write_enable) |-> (rsp_new_pixel == 32'd0))
      else $error("non-write beat carries a nonzero pixel");

   a_write_opaque: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_write_enable) |-> (rsp_new_pixel[31:24] == 8'hFF))
      else $error("written pixel alpha is not opaque");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while output is empty");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_new_pixel)
                                     && $stable(rsp_write_enable)))
      else $error("stalled result beat changed");

endmodule

bind glyph_coverage_blend_clip gcbc_checker u_gcbc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_write_enable (rsp_chan.write_enable),
   .rsp_new_pixel    (rsp_chan.new_pixel)
);
`default_nettype wire

### test/testbench.sv
// Testbench for glyph_coverage_blend_clip: directed and random beats against a predictor.
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import gcbc_pkg::*;

   localparam int CYCLE_LIMIT    = 300000;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_BEATS    = 185;
   localparam int DRAIN_CYCLES   = 8;

   typedef struct packed {
      logic               write_enable;
      logic [PIXEL_W-1:0] new_pixel;
   } blend_result_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   gcbc_req_if req_chan ();
   gcbc_rsp_if rsp_chan ();

   glyph_coverage_blend_clip DUT (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   cfg_type          blend_cfg;
   blend_result_type pending_pixels[$];
   int               error_count;
   int               result_count;
   int               cycle_count;
   int               hold_off_cycles;
   bit               idle_on;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("testbench: FAIL");
      $finish;
   end

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on result %0d, %s: got %h, expected %h",
               result_count, field, got, want);
      error_count++;
   endtask

   function automatic logic [CHAN_W-1:0] mix_channel(input logic [CHAN_W-1:0] fg,
                                                     input logic [CHAN_W-1:0] bg,
                                                     input int a);
      int sum;
      sum = int'(fg) * a + int'(bg) * (int'(CHAN_MAX) - a);
      return CHAN_W'(sum / int'(CHAN_MAX));
   endfunction

   function automatic blend_result_type blend_pixel(input logic [CHAN_W-1:0] cov,
                                                    input logic signed [COORD_W-1:0] col,
                                                    input logic signed [COORD_W-1:0] row,
                                                    input logic [RGB_W-1:0] dest);
      blend_result_type res;
      int               x;
      int               y;
      int               eff;
      bit               hit;
      logic [CHAN_W-1:0] r;
      logic [CHAN_W-1:0] g;
      logic [CHAN_W-1:0] b;
      res = '0;
      x = col;
      y = row;
      hit = x >= int'(blend_cfg.clip_left) && x < int'(blend_cfg.clip_right) &&
            y >= int'(blend_cfg.clip_top) && y < int'(blend_cfg.clip_bottom);
      eff = (int'(cov) * int'(blend_cfg.text_alpha)) / int'(CHAN_MAX);
      if (!hit || eff == 0) begin
         return res;
      end
      if (eff == int'(CHAN_MAX)) begin
         r = blend_cfg.text_red;
         g = blend_cfg.text_green;
         b = blend_cfg.text_blue;
      end else begin
         r = mix_channel(blend_cfg.text_red, dest[23:16], eff);
         g = mix_channel(blend_cfg.text_green, dest[15:8], eff);
         b = mix_channel(blend_cfg.text_blue, dest[7:0], eff);
      end
      res.write_enable = 1'b1;
      res.new_pixel = {ALPHA_OPAQUE, r, g, b};
      return res;
   endfunction

   initial begin : check_results
      blend_result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            if (pending_pixels.size() == 0) begin
               report_mismatch("unexpected beat", 32'(rsp_chan.write_enable),
                               rsp_chan.new_pixel);
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_chan.write_enable !== want.write_enable)
                  report_mismatch("write_enable", 32'(rsp_chan.write_enable),
                                  32'(want.write_enable));
               if (rsp_chan.new_pixel !== want.new_pixel)
                  report_mismatch("new_pixel", rsp_chan.new_pixel, want.new_pixel);
            end
            result_count++;
         end
      end
   end

   // result side: random stalls, plus long hold-offs on request
   initial begin : drive_result_ready
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
            rsp_chan.ready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic send_pixel(input logic [CHAN_W-1:0] cov,
                             input logic signed [COORD_W-1:0] col,
                             input logic signed [COORD_W-1:0] row,
                             input logic [RGB_W-1:0] dest);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.coverage      <= cov;
      req_chan.target_column <= col;
      req_chan.target_row    <= row;
      req_chan.dest_rgb      <= dest;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      pending_pixels.push_back(blend_pixel(cov, col, row, dest));
   endtask

   task automatic wait_for_pixels_out();
      req_chan.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (idx)
         CSR_TEXT_RED:    blend_cfg.text_red    = data[CHAN_W-1:0];
         CSR_TEXT_GREEN:  blend_cfg.text_green  = data[CHAN_W-1:0];
         CSR_TEXT_BLUE:   blend_cfg.text_blue   = data[CHAN_W-1:0];
         CSR_TEXT_ALPHA:  blend_cfg.text_alpha  = data[CHAN_W-1:0];
         CSR_CLIP_LEFT:   blend_cfg.clip_left   = data[CLIP_W-1:0];
         CSR_CLIP_TOP:    blend_cfg.clip_top    = data[CLIP_W-1:0];
         CSR_CLIP_RIGHT:  blend_cfg.clip_right  = data[CLIP_W-1:0];
         CSR_CLIP_BOTTOM: blend_cfg.clip_bottom = data[CLIP_W-1:0];
         default: ;
      endcase
   endtask

   // junk_high puts random bits above the byte registers' width
   task automatic load_settings(input cfg_type s, input bit junk_high);
      logic [CSR_DATA_W-CHAN_W-1:0] top;
      wait_for_pixels_out();
      top = junk_high ? (CSR_DATA_W-CHAN_W)'($urandom | 1) : '0;
      write_register(CSR_TEXT_RED,    {top, s.text_red});
      write_register(CSR_TEXT_GREEN,  {top, s.text_green});
      write_register(CSR_TEXT_BLUE,   {top, s.text_blue});
      write_register(CSR_TEXT_ALPHA,  {top, s.text_alpha});
      write_register(CSR_CLIP_LEFT,   s.clip_left);
      write_register(CSR_CLIP_TOP,    s.clip_top);
      write_register(CSR_CLIP_RIGHT,  s.clip_right);
      write_register(CSR_CLIP_BOTTOM, s.clip_bottom);
      csr_write_enable <= 1'b0;
   endtask

   function automatic cfg_type make_settings(input int red, input int green, input int blue,
                                             input int alpha, input int left, input int top,
                                             input int right, input int bottom);
      cfg_type s;
      s.text_red    = CHAN_W'(red);
      s.text_green  = CHAN_W'(green);
      s.text_blue   = CHAN_W'(blue);
      s.text_alpha  = CHAN_W'(alpha);
      s.clip_left   = CLIP_W'(left);
      s.clip_top    = CLIP_W'(top);
      s.clip_right  = CLIP_W'(right);
      s.clip_bottom = CLIP_W'(bottom);
      return s;
   endfunction

   // mostly inside [lo, hi), some on the edges, some anywhere
   function automatic logic signed [COORD_W-1:0] pick_coordinate(input int lo, input int hi);
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 7 && hi > lo)
         return COORD_W'(lo + $urandom_range(0, hi - lo - 1));
      if (roll < 9) begin
         case ($urandom_range(0, 3))
            0: return COORD_W'(lo - 1);
            1: return COORD_W'(lo);
            2: return COORD_W'(hi - 1);
            default: return COORD_W'(hi);
         endcase
      end
      return COORD_W'($urandom);
   endfunction

   function automatic logic [CHAN_W-1:0] pick_coverage();
      case ($urandom_range(0, 6))
         0: return '0;
         1: return CHAN_MAX;
         default: return CHAN_W'($urandom);
      endcase
   endfunction

   task automatic test_reset_defaults();
      send_pixel(8'd255, 16'sd0, 16'sd0, 24'hFFFFFF);
      send_pixel(8'd255, 16'sd4095, 16'sd4095, 24'h000000);
      send_pixel(8'd255, 16'sd4096, 16'sd0, 24'h123456);
      send_pixel(8'd0, 16'sd5, 16'sd5, 24'hABCDEF);
   endtask

   task automatic test_clip_edges();
      load_settings(make_settings('h12, 'h34, 'h56, 200, 10, 20, 30, 40), 1'b0);
      send_pixel(8'd255, 16'sd10, 16'sd20, 24'h000000);
      send_pixel(8'd255, 16'sd9, 16'sd20, 24'h808080);
      send_pixel(8'd255, 16'sd29, 16'sd39, 24'hFFFFFF);
      send_pixel(8'd255, 16'sd30, 16'sd39, 24'h808080);
      send_pixel(8'd255, 16'sd29, 16'sd40, 24'h808080);
      send_pixel(8'd255, 16'sd10, 16'sd19, 24'h808080);
      send_pixel(8'd255, -16'sd32768, 16'sd25, 24'h808080);
      send_pixel(8'd255, 16'sd32767, 16'sd25, 24'h808080);
   endtask

   task automatic test_alpha_extremes();
      load_settings(make_settings('hFF, 'hFF, 'hFF, 0, 0, 0, 8192, 8192), 1'b0);
      send_pixel(8'd255, 16'sd1, 16'sd1, 24'h000000);
      load_settings(make_settings('hFF, 'h80, 'h00, 1, 0, 0, 8192, 8192), 1'b0);
      send_pixel(8'd254, 16'sd1, 16'sd1, 24'h000000);
      send_pixel(8'd255, 16'sd1, 16'sd1, 24'h00FF80);
      load_settings(make_settings('h00, 'h00, 'h00, 255, 0, 0, 8192, 8192), 1'b0);
      send_pixel(8'd255, 16'sd8191, 16'sd8191, 24'hFFFFFF);
      send_pixel(8'd128, 16'sd2, 16'sd3, 24'hFFFFFF);
      send_pixel(8'd1, 16'sd2, 16'sd3, 24'h808080);
   endtask

   task automatic test_empty_clip();
      load_settings(make_settings('h40, 'h90, 'hE0, 255, 100, 0, 100, 8192), 1'b0);
      send_pixel(8'd255, 16'sd100, 16'sd5, 24'h000000);
      send_pixel(8'd255, 16'sd99, 16'sd5, 24'h000000);
      load_settings(make_settings('h40, 'h90, 'hE0, 255, 0, 8192, 16383, 8192), 1'b1);
      send_pixel(8'd255, 16'sd5, 16'sd8192, 24'h000000);
      load_settings(make_settings('h40, 'h90, 'hE0, 170, 0, 8192, 16383, 16383), 1'b1);
      send_pixel(8'd255, 16'sd16382, 16'sd16382, 24'h0F0F0F);
   endtask

   // receiver holds off while the sender keeps offering, then a full drain and more beats with random stalls
   task automatic test_backpressure();
      load_settings(make_settings('h20, 'hC0, 'h70, 230, 0, 0, 64, 64), 1'b0);
      idle_on = 1'b0;
      hold_off_cycles = 60;
      repeat (40) send_pixel(pick_coverage(), pick_coordinate(0, 64), pick_coordinate(0, 64),
                             RGB_W'($urandom));
      wait_for_pixels_out();
      idle_on = 1'b1;
      repeat (20) send_pixel(pick_coverage(), pick_coordinate(0, 64), pick_coordinate(0, 64),
                             RGB_W'($urandom));
   endtask

   task automatic test_random_blend();
      cfg_type s;
      int      left;
      int      top;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         left = $urandom_range(0, 300);
         top  = $urandom_range(0, 300);
         s = make_settings($urandom, $urandom, $urandom, $urandom_range(2, 254), left, top,
                           left + $urandom_range(1, 400), top + $urandom_range(1, 400));
         case (phase)
            1: begin
               s.text_red = CHAN_MAX;
               s.text_green = CHAN_MAX;
               s.text_blue = CHAN_MAX;
            end
            2: s.text_alpha = '0;
            3: s.text_alpha = 8'd1;
            4: begin
               s.text_alpha = CHAN_MAX;
               s.text_red = '0;
               s.text_green = '0;
               s.text_blue = '0;
            end
            5: s.clip_right = CLIP_W'(left - $urandom_range(0, left));
            6: s = make_settings($urandom, $urandom, $urandom, 255, 0, 0, 8192, 8192);
            7: s = make_settings($urandom, $urandom, $urandom, $urandom,
                                 $urandom_range(8000, 16000), $urandom_range(8000, 16000),
                                 16383, 16383);
            default: ;
         endcase
         load_settings(s, phase[0]);
         idle_on = phase < RANDOM_PHASES - 2;
         repeat (PHASE_BEATS)
            send_pixel(pick_coverage(),
                       pick_coordinate(int'(s.clip_left), int'(s.clip_right)),
                       pick_coordinate(int'(s.clip_top), int'(s.clip_bottom)),
                       RGB_W'($urandom));
      end
   endtask

   initial begin
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_TEXT_RED;
      csr_write_data   <= '0;
      req_chan.valid         <= 1'b0;
      req_chan.coverage      <= '0;
      req_chan.target_column <= '0;
      req_chan.target_row    <= '0;
      req_chan.dest_rgb      <= '0;
      blend_cfg = make_settings(0, 0, 0, 255, 0, 0, 4096, 4096);
      error_count = 0;
      result_count = 0;
      cycle_count = 0;
      hold_off_cycles = 0;
      idle_on = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_clip_edges();
      test_alpha_extremes();
      test_empty_clip();
      test_backpressure();
      test_random_blend();

      wait_for_pixels_out();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_pixels.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
